[hw/rtl/apc_pkg.sv]
// ============================================================================
// apc_pkg: shared constants and tables for the peak compressor
// Holds the log2 and exp2 fraction tables and the dB conversion constants.
// ============================================================================
package apc_pkg;

    localparam logic [15:0] DB_PER_LOG2 = 16'd24660;
    localparam logic [15:0] LOG2_PER_DB = 16'd10885;

    localparam logic [2:0] REG_ATTACK    = 3'd0;
    localparam logic [2:0] REG_RELEASE   = 3'd1;
    localparam logic [2:0] REG_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_SLOPE     = 3'd3;
    localparam logic [2:0] REG_IN_SCALE  = 3'd4;
    localparam logic [2:0] REG_OUT_SCALE = 3'd5;

    // log2(1 + i/32) in Q.12
    function automatic logic [11:0] log2_frac(input logic [4:0] idx);
        logic [11:0] v;
        case (idx)
            5'd0: v = 12'd0;     5'd1: v = 12'd182;   5'd2: v = 12'd358;
            5'd3: v = 12'd530;   5'd4: v = 12'd696;   5'd5: v = 12'd858;
            5'd6: v = 12'd1016;  5'd7: v = 12'd1169;  5'd8: v = 12'd1319;
            5'd9: v = 12'd1465;  5'd10: v = 12'd1607; 5'd11: v = 12'd1746;
            5'd12: v = 12'd1882; 5'd13: v = 12'd2015; 5'd14: v = 12'd2145;
            5'd15: v = 12'd2272; 5'd16: v = 12'd2396; 5'd17: v = 12'd2518;
            5'd18: v = 12'd2637; 5'd19: v = 12'd2754; 5'd20: v = 12'd2869;
            5'd21: v = 12'd2982; 5'd22: v = 12'd3092; 5'd23: v = 12'd3200;
            5'd24: v = 12'd3307; 5'd25: v = 12'd3412; 5'd26: v = 12'd3514;
            5'd27: v = 12'd3615; 5'd28: v = 12'd3715; 5'd29: v = 12'd3812;
            5'd30: v = 12'd3908; default: v = 12'd4003;
        endcase
        return v;
    endfunction

    // 2^(-i/32) in Q1.16
    function automatic logic [16:0] exp2_frac(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0: v = 17'd65536;  5'd1: v = 17'd64132;  5'd2: v = 17'd62757;
            5'd3: v = 17'd61413;  5'd4: v = 17'd60097;  5'd5: v = 17'd58809;
            5'd6: v = 17'd57549;  5'd7: v = 17'd56316;  5'd8: v = 17'd55109;
            5'd9: v = 17'd53928;  5'd10: v = 17'd52773; 5'd11: v = 17'd51642;
            5'd12: v = 17'd50535; 5'd13: v = 17'd49452; 5'd14: v = 17'd48393;
            5'd15: v = 17'd47356; 5'd16: v = 17'd46341; 5'd17: v = 17'd45348;
            5'd18: v = 17'd44376; 5'd19: v = 17'd43425; 5'd20: v = 17'd42495;
            5'd21: v = 17'd41584; 5'd22: v = 17'd40693; 5'd23: v = 17'd39821;
            5'd24: v = 17'd38968; 5'd25: v = 17'd38133; 5'd26: v = 17'd37316;
            5'd27: v = 17'd36516; 5'd28: v = 17'd35734; 5'd29: v = 17'd34968;
            5'd30: v = 17'd34219; default: v = 17'd33485;
        endcase
        return v;
    endfunction

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_PRE   = 11'b00000000010,
        ST_ENV   = 11'b00000000100,
        ST_LZ    = 11'b00000001000,
        ST_DB    = 11'b00000010000,
        ST_GAIN  = 11'b00000100000,
        ST_EXP   = 11'b00001000000,
        ST_LIN   = 11'b00010000000,
        ST_APPLY = 11'b00100000000,
        ST_POST  = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } t_state;

endpackage

[hw/rtl/audio_peak_compressor.sv]
// ============================================================================
// audio_peak_compressor: feed-forward peak dynamic range compressor
// Pre-gain, peak envelope, log2 dB detector, gain computer, exp2 gain, post-gain.
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  input    | i_valid/o_ready, i_sample_in     | in
//  output   | o_valid/i_ready, o_sample_out    | out
//  config   | i_cfg_we, i_cfg_index, i_cfg_data| in
//
// A sequencer steps one shared multiplier through pre-gain, envelope, dB,
// gain, exponent, gain apply and post-gain, each multiply waiting for its
// registered product, with separate steps for the envelope add, the exp2
// lookup and the output load. A new sample is taken only once the last one
// has been loaded into the output register; a zero envelope skips the dB,
// gain, exponent and exp2 lookup steps and applies unity gain.
// The result waits in its own register, so the next sample runs meanwhile; a
// stall holds that next sample in the last step with the input not ready.
// Reset clears envelope, sequencer and output valid, and loads the register defaults.
// ============================================================================
module audio_peak_compressor #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0] o_sample_out,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_index,
    input  logic [((COEF_WIDTH > 16) ? COEF_WIDTH : 16)-1:0] i_cfg_data
);
    import apc_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COEF_WIDTH;
    localparam int AW = SW + 10;
    localparam int BW = (CW + 1 > 18) ? CW + 1 : 18;
    localparam int PW = AW + BW;
    localparam int PB = $clog2(SW);
    localparam logic signed [PW-1:0] SMAX = (PW'(1) <<< (SW - 1)) - PW'(1);
    localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

    logic [CW-1:0] r_attack, r_release, r_slope;
    logic signed [15:0] r_thresh;
    logic [15:0] r_in_scale, r_out_scale;

    t_state r_state;
    logic [SW-2:0] r_env;
    logic signed [SW-1:0] r_x;
    logic signed [SW-1:0] r_y;
    logic [SW-2:0] r_m;
    logic signed [31:0] r_val;
    logic signed [SW-1:0] r_out;
    logic r_ovalid;
    logic w_load;

    logic signed [AW-1:0] w_a;
    logic signed [BW-1:0] w_b;
    logic [4:0] w_shift;
    logic signed [PW-1:0] w_p;
    logic signed [PW-1:0] w_sat;

    apc_mul #(.A_W(AW), .B_W(BW)) u_mul (
        .i_clk   (i_clk),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_shift (w_shift),
        .o_p     (w_p)
    );

    assign w_sat = (w_p > SMAX) ? SMAX : ((w_p < SMIN) ? SMIN : w_p);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack    <= CW'(64066);
            r_release   <= CW'(65387);
            r_thresh    <= '0;
            r_slope     <= '0;
            r_in_scale  <= 16'd4096;
            r_out_scale <= 16'd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ATTACK:    r_attack    <= i_cfg_data[CW-1:0];
                REG_RELEASE:   r_release   <= i_cfg_data[CW-1:0];
                REG_THRESHOLD: r_thresh    <= i_cfg_data[15:0];
                REG_SLOPE:     r_slope     <= i_cfg_data[CW-1:0];
                REG_IN_SCALE:  r_in_scale  <= i_cfg_data[15:0];
                REG_OUT_SCALE: r_out_scale <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // drive the shared multiplier from the current step
    always_comb begin
        w_a = '0;
        w_b = '0;
        w_shift = 5'd0;
        case (r_state)
            ST_IDLE: begin
                w_a = AW'(r_x);
            end
            ST_PRE: begin
                w_a = AW'(r_x);
                w_b = BW'($signed({1'b0, r_in_scale}));
                w_shift = 5'd12;
            end
            ST_ENV: begin
                w_a = AW'($signed({1'b0, r_env}) - $signed({1'b0, r_m}));
                w_b = (r_env < r_m) ? BW'($signed({1'b0, r_attack}))
                                    : BW'($signed({1'b0, r_release}));
                w_shift = 5'(CW);
            end
            ST_DB: begin
                w_a = AW'(r_val);
                w_b = BW'($signed({1'b0, DB_PER_LOG2}));
                w_shift = 5'd16;
            end
            ST_GAIN: begin
                w_a = AW'(r_val);
                w_b = BW'($signed({1'b0, r_slope}));
                w_shift = 5'(CW);
            end
            ST_EXP: begin
                w_a = AW'(r_val);
                w_b = BW'($signed({1'b0, LOG2_PER_DB}));
                w_shift = 5'd12;
            end
            ST_APPLY: begin
                w_a = AW'(r_y);
                w_b = BW'(r_val);
                w_shift = 5'd16;
            end
            ST_POST: begin
                w_a = AW'(r_val);
                w_b = BW'($signed({1'b0, r_out_scale}));
                w_shift = 5'd12;
            end
            default: ;
        endcase
    end

    // leading-one search over the envelope
    logic [PB-1:0] w_lz;
    always_comb begin
        w_lz = '0;
        for (int k = 1; k <= SW - 2; k++) begin
            if (r_env[k]) w_lz = PB'(k);
        end
    end

    logic [SW+4:0] w_norm;
    logic [4:0] w_idx;
    assign w_norm = {5'd0, r_env} << 5;
    assign w_idx  = 5'(w_norm >> w_lz);

    logic signed [31:0] w_q;
    logic [31:0] w_qn;
    assign w_q  = -32'(w_p);
    assign w_qn = 32'(w_q) >> 12;

    // load the output register once it is free or being taken
    assign w_load = (r_state == ST_OUT) && (!r_ovalid || i_ready);

    // sequencer: each multiply step waits for the registered product
    logic r_phase;
    logic signed [SW:0] w_ymag;
    assign w_ymag = (r_y < 0) ? -(SW+1)'(r_y) : (SW+1)'(r_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= 1'b0;
            r_env    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_x <= i_sample_in;
                        r_state <= ST_PRE;
                        r_phase <= 1'b0;
                    end
                end
                ST_PRE: begin
                    r_phase <= ~r_phase;
                    if (r_phase) begin
                        r_y <= SW'(w_sat);
                        r_state <= ST_ENV;
                    end
                end
                ST_ENV: begin
                    if (!r_phase) begin
                        r_m <= (w_ymag > (SW+1)'(SMAX)) ? SMAX[SW-2:0] : w_ymag[SW-2:0];
                        r_phase <= 1'b1;
                    end else if (r_phase && r_state == ST_ENV && w_shift == 5'(CW)) begin
                        r_phase <= 1'b0;
                        r_state <= ST_LZ;
                    end
                end
                ST_LZ: begin
                    r_env <= (SW-1)'($signed({1'b0, r_m}) + w_p);
                    r_state <= ST_DB;
                    r_phase <= 1'b0;
                end
                ST_DB: begin
                    if (r_env == '0) begin
                        r_val <= 32'sd65536;
                        r_state <= ST_APPLY;
                    end else if (!r_phase) begin
                        r_val <= $signed(32'(w_lz) - 32'(SW - 1)) * 32'sd4096
                                 + 32'($signed({1'b0, log2_frac(w_idx)}));
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        r_state <= ST_GAIN;
                    end
                end
                ST_GAIN: begin
                    if (!r_phase) begin
                        r_val <= 32'(r_thresh) - 32'(w_p);
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        r_state <= ST_EXP;
                    end
                end
                ST_EXP: begin
                    if (!r_phase) begin
                        r_val <= (w_p > 0) ? 32'sd0 : 32'(w_p);
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        r_state <= ST_LIN;
                    end
                end
                ST_LIN: begin
                    if (w_qn >= 32'd17) r_val <= '0;
                    else r_val <= 32'(exp2_frac(w_q[11:7]) >> w_qn[4:0]);
                    r_state <= ST_APPLY;
                    r_phase <= 1'b0;
                end
                ST_APPLY: begin
                    r_phase <= ~r_phase;
                    if (r_phase) begin
                        r_val <= 32'(w_p);
                        r_state <= ST_POST;
                    end
                end
                ST_POST: begin
                    r_phase <= ~r_phase;
                    if (r_phase) begin
                        r_y <= SW'(w_sat);
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_load) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // hold the finished sample until its output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_out <= r_y;
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_sample_out = r_out;
endmodule

[hw/rtl/apc_mul.sv]
// ============================================================================
// apc_mul: shared signed multiplier with rounding shift
// Adds half to a*b and shifts right arithmetically, then registers the result.
// ============================================================================
module apc_mul #(
    parameter int A_W = 34,
    parameter int B_W = 18
) (
    input  logic                 i_clk,
    input  logic signed [A_W-1:0] i_a,
    input  logic signed [B_W-1:0] i_b,
    input  logic [4:0]           i_shift,
    output logic signed [A_W+B_W-1:0] o_p
);
    logic signed [A_W+B_W-1:0] r_p;
    logic signed [A_W+B_W-1:0] n_p;
    logic signed [A_W+B_W-1:0] w_half;

    // round to nearest, ties up, then floor shift
    always_comb begin
        w_half = (i_shift == 5'd0) ? '0 :
                 ($signed({{(A_W+B_W-1){1'b0}}, 1'b1}) <<< (i_shift - 5'd1));
        n_p    = (i_a * i_b + w_half) >>> i_shift;
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;
endmodule

[sim/tb_audio_peak_compressor.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_audio_peak_compressor: self-checking bench for the peak compressor
// Drives samples over valid/ready with random gaps, predicts each compressed
// sample from a bit-true model of envelope, dB gain and post-gain, and checks
// every output transfer in order. Several register settings are exercised.
// ============================================================================
module tb_audio_peak_compressor;
    import apc_pkg::*;

    localparam int SW = 24;
    localparam longint SMAX = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint SMIN = -SMAX - 1;
    localparam int WDOG_LIMIT = 20000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    logic [SW-1:0] i_sample_in = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic [SW-1:0] o_sample_out;
    logic          i_cfg_we = 1'b0;
    logic [2:0]    i_cfg_index = '0;
    logic [15:0]   i_cfg_data = '0;

    // gain settings kept by the predictor
    logic [15:0]   attack_q, release_q, slope_q, in_gain_q, out_gain_q;
    logic signed [15:0] thresh_q;
    longint        env_lvl;

    logic [SW-1:0] want_q[$];
    int            errors = 0;
    int            idle_cycles = 0;
    bit            hold_off = 1'b0;

    typedef struct {
        logic [SW-1:0] smp;
        bit            known;
        logic [SW-1:0] out;
    } t_row;

    audio_peak_compressor u_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic longint rnd_shr(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip(longint v);
        return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
    endfunction

    function automatic longint log2_env(longint e);
        int p;
        logic [4:0] idx;
        p = SW - 2;
        while (p > 0 && e[p] == 1'b0) p--;
        if (p >= 5) idx = 5'(e >> (p - 5));
        else idx = 5'(e << (5 - p));
        return longint'(p - (SW - 1)) * 4096 + longint'(log2_frac(idx));
    endfunction

    // advance the envelope and return the compressed sample
    function automatic logic [SW-1:0] compress(logic [SW-1:0] smp);
        longint x, y, m, cf, lin, t, db, g, q, n;
        x = longint'(signed'(smp));
        y = clip(rnd_shr(x * longint'(in_gain_q), 12));
        m = y < 0 ? -y : y;
        if (m > SMAX) m = SMAX;
        cf = env_lvl < m ? longint'(attack_q) : longint'(release_q);
        env_lvl = m + rnd_shr(cf * (env_lvl - m), 16);
        if (env_lvl <= 0) begin
            lin = 65536;
        end else begin
            db = rnd_shr(log2_env(env_lvl) * longint'(DB_PER_LOG2), 16);
            g = rnd_shr(longint'(slope_q) * (longint'(thresh_q) - db), 16);
            if (g > 0) g = 0;
            q = -rnd_shr(g * longint'(LOG2_PER_DB), 12);
            n = q >>> 12;
            if (n >= 17) lin = 0;
            else lin = longint'(exp2_frac(5'(q >>> 7))) >>> n;
        end
        t = rnd_shr(y * lin, 16);
        return SW'(clip(rnd_shr(t * longint'(out_gain_q), 12)));
    endfunction

    task automatic report(string what, logic [SW-1:0] got, logic [SW-1:0] exp_v);
        $display("MISMATCH %s: got %h expected %h", what, got, exp_v);
        errors++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_ATTACK:    attack_q = val;
            REG_RELEASE:   release_q = val;
            REG_THRESHOLD: thresh_q = val;
            REG_SLOPE:     slope_q = val;
            REG_IN_SCALE:  in_gain_q = val;
            REG_OUT_SCALE: out_gain_q = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_all(logic [15:0] a, logic [15:0] r, logic [15:0] th,
                           logic [15:0] sl, logic [15:0] gi, logic [15:0] go);
        write_reg(REG_ATTACK, a);
        write_reg(REG_RELEASE, r);
        write_reg(REG_THRESHOLD, th);
        write_reg(REG_SLOPE, sl);
        write_reg(REG_IN_SCALE, gi);
        write_reg(REG_OUT_SCALE, go);
    endtask

    // offer one sample after a random gap, hold until transferred
    task automatic send(logic [SW-1:0] smp, bit known, logic [SW-1:0] out_v);
        logic [SW-1:0] p;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        p = compress(smp);
        if (known && p !== out_v) report("directed row vs predictor", p, out_v);
        want_q.push_back(known ? out_v : p);
        i_valid     <= 1'b1;
        i_sample_in <= smp;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // receiver: random wait per item, one long hold-off on request
    initial begin
        int gap_n;
        forever begin
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            gap_n = $urandom_range(0, 14);
            if (gap_n > 0) begin
                i_ready <= 1'b0;
                repeat (gap_n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // check each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (want_q.size() == 0) report("unexpected output", o_sample_out, '0);
            else if (o_sample_out !== want_q[0]) report("sample_out", o_sample_out, want_q[0]);
            if (want_q.size() != 0) void'(want_q.pop_front());
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Watchdog expired");
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        int k;
        attack_q = 16'd64066; release_q = 16'd65387; thresh_q = '0; slope_q = '0;
        in_gain_q = 16'd4096; out_gain_q = 16'd4096; env_lvl = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: unity path; zero envelope gives unity gain
        rows = '{
            '{24'h000000, 1'b1, 24'h000000},
            '{24'h7FFFFF, 1'b1, 24'h7FFFFF},
            '{24'h800000, 1'b1, 24'h800000},
            '{24'h000001, 1'b1, 24'h000001},
            '{24'hFFFFFF, 1'b1, 24'hFFFFFF},
            '{24'h400000, 1'b0, 24'h0},
            '{24'hC00000, 1'b0, 24'h0},
            '{24'h123456, 1'b0, 24'h0}
        };
        foreach (rows[i]) send(rows[i].smp, rows[i].known, rows[i].out);
        drain();

        // hard compression, low threshold; extremes and saturating gains
        set_all(16'd0, 16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        rows = '{
            '{24'h7FFFFF, 1'b0, 24'h0}, '{24'h800000, 1'b0, 24'h0},
            '{24'h000000, 1'b0, 24'h0}, '{24'h000001, 1'b0, 24'h0},
            '{24'h000010, 1'b0, 24'h0}, '{24'h7FFFFF, 1'b0, 24'h0}
        };
        foreach (rows[i]) send(rows[i].smp, rows[i].known, rows[i].out);
        drain();
        // zero pre-gain keeps the envelope at zero: output is zero
        set_all(16'hFFFF, 16'd0, 16'h0000, 16'd0, 16'd0, 16'd4096);
        send(24'h7FFFFF, 1'b1, 24'h000000);
        send(24'h800000, 1'b1, 24'h000000);
        drain();
        // index beyond the list is ignored
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'h1234);

        for (k = 0; k < 2000; k++) begin
            if (k % 400 == 0) begin
                drain();
                case (k / 400)
                    0: set_all(16'd64066, 16'd65387, -16'sd5120, 16'd49152, 16'd4096, 16'd4096);
                    1: set_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 32768) * -1),
                               16'($urandom), 16'($urandom), 16'($urandom));
                    2: set_all(16'd0, 16'd0, 16'h8000, 16'hFFFF, 16'd8192, 16'd2048);
                    3: set_all(16'hFFFF, 16'hFFFF, -16'sd2560, 16'd32768, 16'hFFFF, 16'd4096);
                    default: set_all(16'($urandom), 16'($urandom), 16'h0000,
                                     16'($urandom), 16'($urandom_range(0, 8192)), 16'($urandom));
                endcase
            end
            if (k == 1000) hold_off = 1'b1;
            case ($urandom_range(0, 3))
                0: send(SW'($urandom), 1'b0, '0);
                1: send(SW'($urandom_range(0, 255)) - SW'(128), 1'b0, '0);
                2: send($urandom_range(0, 1) ? 24'h7FFFFF - SW'($urandom_range(0, 15))
                                             : 24'h800000 + SW'($urandom_range(0, 15)), 1'b0, '0);
                default: send(SW'($signed(SW'($urandom)) >>> $urandom_range(0, 22)), 1'b0, '0);
            endcase
        end
        drain();
        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
